// File: sv/spi_pkg.sv
// shared types and constants for the segment pair intersection block
package spi_pkg;

    localparam int COORD_W     = 16;
    localparam int POINT_W     = 48;
    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic signed [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic signed [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_end_x;
        logic signed [COORD_W-1:0] first_end_y;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
    } t_item;

    typedef struct packed {
        logic                      segments_meet;
        logic                      lines_parallel;
        logic signed [POINT_W-1:0] cross_x;
        logic signed [POINT_W-1:0] cross_y;
        logic                      point_overflow;
    } t_result;

endpackage

// File: sv/spi_div.sv
// pipelined restoring divider, one quotient bit per stage, with a sideband carried along
module spi_div
    import spi_pkg::*;
#(
    parameter int DW = 68,
    parameter int NW = 35,
    parameter int SW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dvd,
    input  logic [NW-1:0] i_dvs,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic          r_v    [DW];
    logic [NW-1:0] r_rem  [DW];
    logic [DW-1:0] r_q    [DW];
    logic [NW-1:0] r_d    [DW];
    logic [SW-1:0] r_s    [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] q_in;
        logic [NW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [NW:0]   trial;
        logic          take;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign q_in   = i_dvd;
            assign d_in   = i_dvs;
            assign s_in   = i_side;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign d_in   = r_d[k-1];
            assign s_in   = r_s[k-1];
        end

        // dividend bits leave at the top, quotient bits enter at the bottom
        assign trial = {rem_in, q_in[DW-1]};
        assign take  = trial >= {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? NW'(trial - {1'b0, d_in}) : NW'(trial);
            r_q[k]   <= {q_in[DW-2:0], take};
            r_d[k]   <= d_in;
            r_s[k]   <= s_in;
        end
    end

    assign o_valid = r_v[DW-1];
    assign o_quot  = r_q[DW-1];
    assign o_side  = r_s[DW-1];

endmodule

// File: sv/segment_pair_intersection.sv
// top level: segment pair intersection test and line crossing point
//
// usage: put a word of two segments on i_item and raise i_start for one cycle.
// o_busy is always low, so a word is taken in every cycle that i_start is high.
// each word gives exactly one result word on o_result, marked by o_done for
// one cycle, in the order the words came in.
// throughput is one word per cycle.
// the pipeline has six stages of coordinate differences, cross products,
// magnitudes and a split product, then one stage per quotient bit in two
// restoring dividers (x and y share the denominator), then two stages of
// sign, offset and saturation.
// synchronous reset clears the valid bits only; words in flight are dropped.
// the receiver cannot stall, so results are never held back.
module segment_pair_intersection
    import spi_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int CB  = COORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int DFW = CB + 1;           // coordinate difference
    localparam int PW  = 2 * CB + 2;       // one product of differences
    localparam int XW  = 2 * CB + 3;       // cross product
    localparam int NL  = CB + 2;           // low slice of the numerator magnitude
    localparam int LW  = DFW + NL;
    localparam int HW  = DFW + XW - NL;
    localparam int MW  = DFW + XW;         // full direction times numerator
    localparam int DW  = MW + F;           // dividend
    localparam int QX  = (DW > 64) ? DW : 64;
    localparam int SWX = CB + 1;
    localparam int SWY = CB + 3;
    localparam int LAT = DW + 8;

    function automatic logic signed [CB-1:0] sx(input logic [COORD_W-1:0] f);
        logic [31:0] z;
        z = 32'(f);
        return z[CB-1:0];
    endfunction

    function automatic logic signed [DFW-1:0] df(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b);
        return DFW'(a) - DFW'(b);
    endfunction

    function automatic logic between(input logic signed [CB-1:0] p,
                                     input logic signed [CB-1:0] a,
                                     input logic signed [CB-1:0] b);
        return (a <= p && p <= b) || (b <= p && p <= a);
    endfunction

    function automatic logic is_pos(input logic signed [XW-1:0] d);
        return !d[XW-1] && (d != '0);
    endfunction

    function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] d);
        return d[XW-1] ? unsigned'(-d) : unsigned'(d);
    endfunction

    assign o_busy = 1'b0;

    // stage 1: coordinates and differences
    logic                  r_v1;
    logic signed [CB-1:0]  r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_ex, r_ey;
    logic signed [DFW-1:0] r_acx, r_acy, r_bcx, r_bcy, r_ecx, r_ecy;
    logic signed [DFW-1:0] r_cax, r_cay, r_eax, r_eay, r_bax, r_bay;
    logic signed [CB-1:0]  n_ax, n_ay, n_bx, n_by, n_cx, n_cy, n_ex, n_ey;

    assign n_ax = sx(i_item.first_start_x);
    assign n_ay = sx(i_item.first_start_y);
    assign n_bx = sx(i_item.first_end_x);
    assign n_by = sx(i_item.first_end_y);
    assign n_cx = sx(i_item.second_start_x);
    assign n_cy = sx(i_item.second_start_y);
    assign n_ex = sx(i_item.second_end_x);
    assign n_ey = sx(i_item.second_end_y);

    always_ff @(posedge i_clk) begin
        r_ax  <= n_ax;  r_ay <= n_ay;  r_bx <= n_bx;  r_by <= n_by;
        r_cx  <= n_cx;  r_cy <= n_cy;  r_ex <= n_ex;  r_ey <= n_ey;
        r_acx <= df(n_ax, n_cx);  r_acy <= df(n_ay, n_cy);
        r_bcx <= df(n_bx, n_cx);  r_bcy <= df(n_by, n_cy);
        r_ecx <= df(n_ex, n_cx);  r_ecy <= df(n_ey, n_cy);
        r_cax <= df(n_cx, n_ax);  r_cay <= df(n_cy, n_ay);
        r_eax <= df(n_ex, n_ax);  r_eay <= df(n_ey, n_ay);
        r_bax <= df(n_bx, n_ax);  r_bay <= df(n_by, n_ay);
    end

    // stage 2: products and bounding box tests
    logic                  r_v2;
    logic signed [PW-1:0]  r_p1a, r_p1b, r_p2a, r_p2b, r_p3a, r_p3b;
    logic signed [PW-1:0]  r_p4a, r_p4b, r_pna, r_pnb, r_pda, r_pdb;
    logic [3:0]            r_box2;
    logic signed [DFW-1:0] r_dx2, r_dy2;
    logic signed [CB-1:0]  r_ax2, r_ay2;

    always_ff @(posedge i_clk) begin
        r_p1a <= r_acx * r_ecy;  r_p1b <= r_acy * r_ecx;
        r_p2a <= r_bcx * r_ecy;  r_p2b <= r_bcy * r_ecx;
        r_p3a <= r_cax * r_bay;  r_p3b <= r_cay * r_bax;
        r_p4a <= r_eax * r_bay;  r_p4b <= r_eay * r_bax;
        r_pna <= r_ecx * r_cay;  r_pnb <= r_ecy * r_cax;
        r_pda <= r_ecx * r_bay;  r_pdb <= r_ecy * r_bax;
        r_box2[0] <= between(r_ax, r_cx, r_ex) && between(r_ay, r_cy, r_ey);
        r_box2[1] <= between(r_bx, r_cx, r_ex) && between(r_by, r_cy, r_ey);
        r_box2[2] <= between(r_cx, r_ax, r_bx) && between(r_cy, r_ay, r_by);
        r_box2[3] <= between(r_ex, r_ax, r_bx) && between(r_ey, r_ay, r_by);
        r_dx2 <= r_bax;
        r_dy2 <= r_bay;
        r_ax2 <= r_ax;
        r_ay2 <= r_ay;
    end

    // stage 3: cross products
    logic                  r_v3;
    logic signed [XW-1:0]  r_d1, r_d2, r_d3, r_d4, r_num, r_den;
    logic [3:0]            r_box3;
    logic signed [DFW-1:0] r_dx3, r_dy3;
    logic signed [CB-1:0]  r_ax3, r_ay3;

    always_ff @(posedge i_clk) begin
        r_d1   <= XW'(r_p1a) - XW'(r_p1b);
        r_d2   <= XW'(r_p2a) - XW'(r_p2b);
        r_d3   <= XW'(r_p3a) - XW'(r_p3b);
        r_d4   <= XW'(r_p4a) - XW'(r_p4b);
        r_num  <= XW'(r_pna) - XW'(r_pnb);
        r_den  <= XW'(r_pda) - XW'(r_pdb);
        r_box3 <= r_box2;
        r_dx3  <= r_dx2;
        r_dy3  <= r_dy2;
        r_ax3  <= r_ax2;
        r_ay3  <= r_ay2;
    end

    // stage 4: meet decision and magnitudes
    logic                 r_v4;
    logic                 r_meet4, r_par4, r_negx4, r_negy4;
    logic [DFW-1:0]       r_mdx4, r_mdy4;
    logic [XW-1:0]        r_mnum4, r_mden4;
    logic signed [CB-1:0] r_ax4, r_ay4;
    logic                 n_proper;
    logic                 n_touch;

    assign n_proper = ((is_pos(r_d1) && r_d2[XW-1]) || (r_d1[XW-1] && is_pos(r_d2))) &&
                      ((is_pos(r_d3) && r_d4[XW-1]) || (r_d3[XW-1] && is_pos(r_d4)));
    assign n_touch  = (r_d1 == '0 && r_box3[0]) || (r_d2 == '0 && r_box3[1]) ||
                      (r_d3 == '0 && r_box3[2]) || (r_d4 == '0 && r_box3[3]);

    always_ff @(posedge i_clk) begin
        r_meet4 <= n_proper || n_touch;
        r_par4  <= r_den == '0;
        r_negx4 <= r_dx3[DFW-1] ^ r_num[XW-1] ^ r_den[XW-1];
        r_negy4 <= r_dy3[DFW-1] ^ r_num[XW-1] ^ r_den[XW-1];
        r_mdx4  <= r_dx3[DFW-1] ? unsigned'(-r_dx3) : unsigned'(r_dx3);
        r_mdy4  <= r_dy3[DFW-1] ? unsigned'(-r_dy3) : unsigned'(r_dy3);
        r_mnum4 <= mag_x(r_num);
        r_mden4 <= mag_x(r_den);
        r_ax4   <= r_ax3;
        r_ay4   <= r_ay3;
    end

    // stage 5: partial products of direction and numerator
    logic                 r_v5;
    logic [LW-1:0]        r_plx, r_ply;
    logic [HW-1:0]        r_phx, r_phy;
    logic                 r_meet5, r_par5, r_negx5, r_negy5;
    logic [XW-1:0]        r_mden5;
    logic signed [CB-1:0] r_ax5, r_ay5;

    always_ff @(posedge i_clk) begin
        r_plx   <= r_mdx4 * r_mnum4[NL-1:0];
        r_ply   <= r_mdy4 * r_mnum4[NL-1:0];
        r_phx   <= r_mdx4 * r_mnum4[XW-1:NL];
        r_phy   <= r_mdy4 * r_mnum4[XW-1:NL];
        r_meet5 <= r_meet4;
        r_par5  <= r_par4;
        r_negx5 <= r_negx4;
        r_negy5 <= r_negy4;
        r_mden5 <= r_mden4;
        r_ax5   <= r_ax4;
        r_ay5   <= r_ay4;
    end

    // stage 6: dividends
    logic                 r_v6;
    logic [DW-1:0]        r_dvdx, r_dvdy;
    logic [XW-1:0]        r_mden6;
    logic [SWX-1:0]       r_sidex;
    logic [SWY-1:0]       r_sidey;

    always_ff @(posedge i_clk) begin
        r_dvdx  <= DW'(MW'(r_plx) + (MW'(r_phx) << NL)) << F;
        r_dvdy  <= DW'(MW'(r_ply) + (MW'(r_phy) << NL)) << F;
        r_mden6 <= r_mden5;
        r_sidex <= {r_negx5, r_ax5};
        r_sidey <= {r_meet5, r_par5, r_negy5, r_ay5};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_start && !o_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    logic           divx_v, divy_v;
    logic [DW-1:0]  quotx, quoty;
    logic [SWX-1:0] sidex;
    logic [SWY-1:0] sidey;

    spi_div #(.DW(DW), .NW(XW), .SW(SWX)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_dvd   (r_dvdx),
        .i_dvs   (r_mden6),
        .i_side  (r_sidex),
        .o_valid (divx_v),
        .o_quot  (quotx),
        .o_side  (sidex)
    );

    spi_div #(.DW(DW), .NW(XW), .SW(SWY)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_dvd   (r_dvdy),
        .i_dvs   (r_mden6),
        .i_side  (r_sidey),
        .o_valid (divy_v),
        .o_quot  (quoty),
        .o_side  (sidey)
    );

    // stage f1: signed quotient and scaled base
    logic                    r_vf;
    logic                    r_bigx, r_bigy, r_negxf, r_negyf, r_meetf, r_parf;
    logic signed [63:0]      r_qx, r_qy, r_bx64, r_by64;
    logic [QX-1:0]           n_qxw, n_qyw;
    logic [63:0]             n_qxm, n_qym;

    assign n_qxw = QX'(quotx);
    assign n_qyw = QX'(quoty);
    assign n_qxm = {2'b00, n_qxw[61:0]};
    assign n_qym = {2'b00, n_qyw[61:0]};

    always_ff @(posedge i_clk) begin
        r_bigx  <= |n_qxw[QX-1:62];
        r_bigy  <= |n_qyw[QX-1:62];
        r_negxf <= sidex[CB];
        r_negyf <= sidey[CB];
        r_meetf <= sidey[CB+2];
        r_parf  <= sidey[CB+1];
        r_qx    <= sidex[CB] ? -signed'(n_qxm) : signed'(n_qxm);
        r_qy    <= sidey[CB] ? -signed'(n_qym) : signed'(n_qym);
        r_bx64  <= 64'(signed'(sidex[CB-1:0])) <<< F;
        r_by64  <= 64'(signed'(sidey[CB-1:0])) <<< F;
    end

    // saturate one coordinate to the point range, flag in the top bit
    function automatic logic [POINT_W:0] sat(input logic big, input logic neg,
                                             input logic signed [63:0] s);
        logic fits;
        fits = (s[63:POINT_W-1] == '0) || (s[63:POINT_W-1] == '1);
        if (big) begin
            return {1'b1, neg ? POINT_MIN : POINT_MAX};
        end else if (!fits) begin
            return {1'b1, s[63] ? POINT_MIN : POINT_MAX};
        end
        return {1'b0, s[POINT_W-1:0]};
    endfunction

    // stage f2: offset, saturate, result register
    logic               r_done;
    t_result            r_res;
    logic [POINT_W:0]   n_sx, n_sy;

    assign n_sx = sat(r_bigx, r_negxf, r_qx + r_bx64);
    assign n_sy = sat(r_bigy, r_negyf, r_qy + r_by64);

    always_ff @(posedge i_clk) begin
        r_res.segments_meet  <= r_meetf;
        r_res.lines_parallel <= r_parf;
        r_res.cross_x        <= r_parf ? '0 : n_sx[POINT_W-1:0];
        r_res.cross_y        <= r_parf ? '0 : n_sy[POINT_W-1:0];
        r_res.point_overflow <= !r_parf && (n_sx[POINT_W] || n_sy[POINT_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vf   <= divx_v && divy_v;
            r_done <= r_vf;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##LAT o_done)
        else $error("result word missing after pipeline latency");

    a_div_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        divx_v == divy_v)
        else $error("x and y dividers out of step");

    a_parallel_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.lines_parallel |->
            o_result.cross_x == '0 && o_result.cross_y == '0 && !o_result.point_overflow)
        else $error("parallel lines with nonzero point");

    a_ovf_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.point_overflow |->
            o_result.cross_x == POINT_MAX || o_result.cross_x == POINT_MIN ||
            o_result.cross_y == POINT_MAX || o_result.cross_y == POINT_MIN)
        else $error("overflow flagged without a saturated coordinate");
`endif

endmodule
